// ----- rtl/clpp_pkg.sv -----
// Shared types, codes and defaults for the cell-list particle pressure engine.
`default_nettype none

package clpp_pkg;

    localparam int DEF_MAX_PARTICLES = 4096;
    localparam int DEF_GRID_X        = 32;
    localparam int DEF_GRID_Y        = 32;
    localparam int DEF_GRID_Z        = 32;

    localparam int APB_AW = 5;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] KIND_GHOST = 2'd0;
    localparam logic [1:0] KIND_FLUID = 2'd1;
    localparam logic [1:0] KIND_WALL  = 2'd2;

    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z     = 3'd2;
    localparam logic [2:0] REG_CELL_SCALE   = 3'd3;
    localparam logic [2:0] REG_RADIUS       = 3'd4;
    localparam logic [2:0] REG_REST_DENSITY = 3'd5;
    localparam logic [2:0] REG_GAIN_FLUID   = 3'd6;
    localparam logic [2:0] REG_GAIN_WALL    = 3'd7;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [11:0]        particle_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [1:0]         kind;
    } in_t;

    typedef struct packed {
        logic [11:0] result_index;
        logic [23:0] density;
        logic [31:0] pressure;
        logic        out_of_grid;
    } out_t;

    typedef struct packed {
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic signed [23:0] origin_z;
        logic [23:0]        cell_scale;
        logic [22:0]        radius;
        logic [23:0]        rest_density;
        logic [31:0]        gain_fluid;
        logic [31:0]        gain_wall;
    } cfg_t;

    function automatic logic is_real(input logic [1:0] k);
        return (k == KIND_FLUID) || (k == KIND_WALL);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cell_list_particle_pressure.sv -----
// Top level of the cell-list particle number density and pressure engine.
`default_nettype none

// Particles live in a slot memory (position and kind) with a per-slot link
// memory; a cell table memory holds the head and tail of each cell's list.
// All work is sequenced over these synchronous memories (one write and one
// read port each), one access per cycle, so one item is handled at a time.
// After reset, and for each clear beat, the cell table is swept one cell per
// cycle; input stalls meanwhile while configuration writes are still taken.
// A ghost insert only writes its slot; a real insert also finds its cell and,
// inside the grid, reads the cell entry, writes the new head and tail and the
// slot's terminator, then links the old tail. A query loads the particle (a
// ghost query ends there), finds its cell and squares the radius, then walks
// each neighbour cell's list, checks the distance to each real node other
// than itself and, for each one inside the radius, runs 23 square-root steps
// and 39 divide steps (only the root when the positions coincide), then
// computes the pressure. A result sits in an output register, so the next
// beat is taken while it waits.
module cell_list_particle_pressure #(
    parameter int MAX_PARTICLES = clpp_pkg::DEF_MAX_PARTICLES,
    parameter int GRID_X        = clpp_pkg::DEF_GRID_X,
    parameter int GRID_Y        = clpp_pkg::DEF_GRID_Y,
    parameter int GRID_Z        = clpp_pkg::DEF_GRID_Z
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire clpp_pkg::in_t               in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output clpp_pkg::out_t                   out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [clpp_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    localparam int IW     = $clog2(MAX_PARTICLES);
    localparam int PW     = IW + 1;
    localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int CW     = $clog2(NCELLS);

    clpp_pkg::cfg_t cfg;

    logic            pos_we, pos_re;
    logic [IW-1:0]   pos_waddr, pos_raddr;
    logic [73:0]     pos_wdata, pos_rdata;
    logic            link_we, link_re;
    logic [IW-1:0]   link_waddr, link_raddr;
    logic [PW-1:0]   link_wdata, link_rdata;
    logic            cell_we, cell_re;
    logic [CW-1:0]   cell_waddr, cell_raddr;
    logic [2*PW-1:0] cell_wdata, cell_rdata;
    logic            wu_start, wu_done;
    logic [45:0]     wu_d2;
    logic [39:0]     wu_weight;

    clpp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clpp_ram #(.WIDTH(74), .DEPTH(MAX_PARTICLES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    clpp_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    clpp_ram #(.WIDTH(2 * PW), .DEPTH(NCELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    clpp_wunit u_wunit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (wu_start),
        .d2     (wu_d2),
        .radius (cfg.radius),
        .done   (wu_done),
        .weight (wu_weight)
    );

    clpp_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .GRID_X        (GRID_X),
        .GRID_Y        (GRID_Y),
        .GRID_Z        (GRID_Z)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg        (cfg),
        .pos_we     (pos_we),
        .pos_waddr  (pos_waddr),
        .pos_wdata  (pos_wdata),
        .pos_re     (pos_re),
        .pos_raddr  (pos_raddr),
        .pos_rdata  (pos_rdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_re    (link_re),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata),
        .cell_we    (cell_we),
        .cell_waddr (cell_waddr),
        .cell_wdata (cell_wdata),
        .cell_re    (cell_re),
        .cell_raddr (cell_raddr),
        .cell_rdata (cell_rdata),
        .wu_start   (wu_start),
        .wu_d2      (wu_d2),
        .wu_done    (wu_done),
        .wu_weight  (wu_weight)
    );

endmodule

`default_nettype wire

// ----- rtl/clpp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module clpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/clpp_cfg.sv -----
// APB-style configuration register file.
`default_nettype none

module clpp_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [clpp_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output clpp_pkg::cfg_t                   cfg
);

    clpp_pkg::cfg_t cfg_reg;
    logic [2:0]     sel;

    assign sel    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{origin_x:     24'sd0,
                         origin_y:     24'sd0,
                         origin_z:     24'sd0,
                         cell_scale:   24'd65536,
                         radius:       23'd0,
                         rest_density: 24'd0,
                         gain_fluid:   32'd0,
                         gain_wall:    32'd0};
        end
        else if (psel && penable && pwrite)
        begin
            case (sel)
                clpp_pkg::REG_ORIGIN_X:     cfg_reg.origin_x     <= pwdata[23:0];
                clpp_pkg::REG_ORIGIN_Y:     cfg_reg.origin_y     <= pwdata[23:0];
                clpp_pkg::REG_ORIGIN_Z:     cfg_reg.origin_z     <= pwdata[23:0];
                clpp_pkg::REG_CELL_SCALE:   cfg_reg.cell_scale   <= pwdata[23:0];
                clpp_pkg::REG_RADIUS:       cfg_reg.radius       <= pwdata[22:0];
                clpp_pkg::REG_REST_DENSITY: cfg_reg.rest_density <= pwdata[23:0];
                clpp_pkg::REG_GAIN_FLUID:   cfg_reg.gain_fluid   <= pwdata;
                clpp_pkg::REG_GAIN_WALL:    cfg_reg.gain_wall    <= pwdata;
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            clpp_pkg::REG_ORIGIN_X:     prdata = {8'b0, cfg_reg.origin_x};
            clpp_pkg::REG_ORIGIN_Y:     prdata = {8'b0, cfg_reg.origin_y};
            clpp_pkg::REG_ORIGIN_Z:     prdata = {8'b0, cfg_reg.origin_z};
            clpp_pkg::REG_CELL_SCALE:   prdata = {8'b0, cfg_reg.cell_scale};
            clpp_pkg::REG_RADIUS:       prdata = {9'b0, cfg_reg.radius};
            clpp_pkg::REG_REST_DENSITY: prdata = {8'b0, cfg_reg.rest_density};
            clpp_pkg::REG_GAIN_FLUID:   prdata = cfg_reg.gain_fluid;
            clpp_pkg::REG_GAIN_WALL:    prdata = cfg_reg.gain_wall;
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/clpp_wunit.sv -----
// Iterative weight unit: integer square root, then radius/dist minus one by restoring division.
`default_nettype none

module clpp_wunit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [45:0] d2,
    input  wire logic [22:0] radius,
    output logic             done,
    output logic      [39:0] weight
);

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_SQRT = 2'd1;
    localparam logic [1:0] W_DIV  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [45:0] v_reg, v_next;
    logic [45:0] res_reg, res_next;
    logic [45:0] bit_reg, bit_next;
    logic [22:0] root_reg, root_next;
    logic [38:0] num_reg, num_next;
    logic [22:0] rem_reg, rem_next;
    logic [38:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [39:0] weight_reg, weight_next;

    logic [45:0] trial_s;
    logic [45:0] res_step;
    logic [23:0] trial_d;
    logic        qbit;
    logic [38:0] q_step;

    assign done   = done_reg;
    assign weight = weight_reg;

    always_comb
    begin
        state_next  = state_reg;
        v_next      = v_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        root_next   = root_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        weight_next = weight_reg;

        trial_s  = res_reg + bit_reg;
        res_step = (v_reg >= trial_s) ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        trial_d  = {rem_reg, num_reg[38]};
        qbit     = (trial_d >= {1'b0, root_reg});
        q_step   = {q_reg[37:0], qbit};

        case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    v_next     = d2;
                    res_next   = '0;
                    bit_next   = 46'd1 << 44;
                    state_next = W_SQRT;
                end
            end
            W_SQRT:
            begin
                if (v_reg >= trial_s)
                begin
                    v_next = v_reg - trial_s;
                end
                res_next = res_step;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    root_next = res_step[22:0];
                    if (res_step[22:0] == 23'd0)
                    begin
                        weight_next = 40'hFF_FFFF;
                        done_next   = 1'b1;
                        state_next  = W_IDLE;
                    end
                    else
                    begin
                        num_next   = {radius, 16'b0};
                        rem_next   = '0;
                        q_next     = '0;
                        cnt_next   = 6'd38;
                        state_next = W_DIV;
                    end
                end
            end
            W_DIV:
            begin
                rem_next = qbit ? 23'(trial_d - {1'b0, root_reg}) : trial_d[22:0];
                num_next = {num_reg[37:0], 1'b0};
                q_next   = q_step;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    weight_next = {1'b0, q_step} - 40'd65536;
                    done_next   = 1'b1;
                    state_next  = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        root_reg   <= root_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        weight_reg <= weight_next;
    end

endmodule

`default_nettype wire

// ----- rtl/clpp_ctrl.sv -----
// Sequencer: grid sweep, insert linking, neighbour-list walk and pressure.
`default_nettype none

module clpp_ctrl #(
    parameter int MAX_PARTICLES = clpp_pkg::DEF_MAX_PARTICLES,
    parameter int GRID_X        = clpp_pkg::DEF_GRID_X,
    parameter int GRID_Y        = clpp_pkg::DEF_GRID_Y,
    parameter int GRID_Z        = clpp_pkg::DEF_GRID_Z,
    localparam int IW           = $clog2(MAX_PARTICLES),
    localparam int PW           = IW + 1,
    localparam int NCELLS       = GRID_X * GRID_Y * GRID_Z,
    localparam int CW           = $clog2(NCELLS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire clpp_pkg::in_t    in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output clpp_pkg::out_t        out_data,
    input  wire clpp_pkg::cfg_t   cfg,
    // particle store
    output logic                  pos_we,
    output logic [IW-1:0]         pos_waddr,
    output logic [73:0]           pos_wdata,
    output logic                  pos_re,
    output logic [IW-1:0]         pos_raddr,
    input  wire logic [73:0]      pos_rdata,
    // link store
    output logic                  link_we,
    output logic [IW-1:0]         link_waddr,
    output logic [PW-1:0]         link_wdata,
    output logic                  link_re,
    output logic [IW-1:0]         link_raddr,
    input  wire logic [PW-1:0]    link_rdata,
    // cell head/tail table
    output logic                  cell_we,
    output logic [CW-1:0]         cell_waddr,
    output logic [2*PW-1:0]       cell_wdata,
    output logic                  cell_re,
    output logic [CW-1:0]         cell_raddr,
    input  wire logic [2*PW-1:0]  cell_rdata,
    // weight unit
    output logic                  wu_start,
    output logic [45:0]           wu_d2,
    input  wire logic             wu_done,
    input  wire logic [39:0]      wu_weight
);

    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int ZW = $clog2(GRID_Z);
    localparam logic [PW-1:0] EMPTY = '1;
    localparam logic [PW-1:0] PMAX  = PW'(MAX_PARTICLES);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_CHK  = 5'd2;
    localparam logic [4:0] S_MX   = 5'd3;
    localparam logic [4:0] S_MY   = 5'd4;
    localparam logic [4:0] S_MZ   = 5'd5;
    localparam logic [4:0] S_MC   = 5'd6;
    localparam logic [4:0] S_LIN  = 5'd7;
    localparam logic [4:0] S_CRD  = 5'd8;
    localparam logic [4:0] S_CWT  = 5'd9;
    localparam logic [4:0] S_LNK  = 5'd10;
    localparam logic [4:0] S_R2   = 5'd11;
    localparam logic [4:0] S_NB   = 5'd12;
    localparam logic [4:0] S_HRD  = 5'd13;
    localparam logic [4:0] S_HWT  = 5'd14;
    localparam logic [4:0] S_WLK  = 5'd15;
    localparam logic [4:0] S_WWT  = 5'd16;
    localparam logic [4:0] S_DX   = 5'd17;
    localparam logic [4:0] S_DY   = 5'd18;
    localparam logic [4:0] S_DZ   = 5'd19;
    localparam logic [4:0] S_DS   = 5'd20;
    localparam logic [4:0] S_CMP  = 5'd21;
    localparam logic [4:0] S_WU   = 5'd22;
    localparam logic [4:0] S_NXT  = 5'd23;
    localparam logic [4:0] S_PR   = 5'd24;
    localparam logic [4:0] S_PW   = 5'd25;
    localparam logic [4:0] S_OUT  = 5'd26;

    logic [4:0]         state_reg, state_next;
    logic [CW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               query_reg, query_next;
    logic [11:0]        idx_reg, idx_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic [23:0]        px_reg, px_next;
    logic [23:0]        py_reg, py_next;
    logic [23:0]        pz_reg, pz_next;
    logic [1:0]         kind_reg, kind_next;
    logic [17:0]        cx_reg, cx_next;
    logic [17:0]        cy_reg, cy_next;
    logic [17:0]        cz_reg, cz_next;
    logic [45:0]        r2_reg, r2_next;
    logic [1:0]         ox_reg, ox_next;
    logic [1:0]         oy_reg, oy_next;
    logic [1:0]         oz_reg, oz_next;
    logic [CW-1:0]      lin_reg, lin_next;
    logic [PW-1:0]      tail_reg, tail_next;
    logic [PW-1:0]      j_reg, j_next;
    logic [PW-1:0]      n_reg, n_next;
    logic [51:0]        d2_reg, d2_next;
    logic [23:0]        dens_reg, dens_next;
    logic [31:0]        press_reg, press_next;
    logic               oog_reg, oog_next;
    logic signed [58:0] prod_reg, prod_next;
    logic               out_valid_reg, out_valid_next;
    clpp_pkg::out_t     out_data_reg, out_data_next;

    logic               accept;
    logic               idx_ok;
    logic [IW-1:0]      in_slot;
    logic signed [25:0] mul_a;
    logic signed [32:0] mul_b;
    logic [18:0]        nx, ny, nz;
    logic               in_g;
    logic [CW-1:0]      lin_calc;
    logic [PW-1:0]      head_rd, tail_rd;
    logic [23:0]        qx, qy, qz;
    logic [1:0]         qk;
    logic [39:0]        dens_sum;
    logic [23:0]        dens_diff;
    logic [31:0]        gain_sel;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign idx_ok    = (32'(in_data.particle_index) < MAX_PARTICLES);
    assign in_slot   = IW'(in_data.particle_index);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign qx = pos_rdata[73:50];
    assign qy = pos_rdata[49:26];
    assign qz = pos_rdata[25:2];
    assign qk = pos_rdata[1:0];

    assign head_rd = cell_rdata[2*PW-1:PW];
    assign tail_rd = cell_rdata[PW-1:0];

    assign dens_sum  = {16'b0, dens_reg} + wu_weight;
    assign dens_diff = dens_reg - cfg.rest_density;
    assign gain_sel  = (kind_reg == clpp_pkg::KIND_FLUID) ? cfg.gain_fluid : cfg.gain_wall;

    // Cell under test: own cell plus offset (offset code 1 is the centre).
    assign nx   = {cx_reg[17], cx_reg} + {17'b0, ox_reg} - 19'd1;
    assign ny   = {cy_reg[17], cy_reg} + {17'b0, oy_reg} - 19'd1;
    assign nz   = {cz_reg[17], cz_reg} + {17'b0, oz_reg} - 19'd1;
    assign in_g = !nx[18] && (nx < 19'(GRID_X))
               && !ny[18] && (ny < 19'(GRID_Y))
               && !nz[18] && (nz < 19'(GRID_Z));
    assign lin_calc = CW'(nz[ZW-1:0]) * CW'(GRID_X * GRID_Y)
                    + CW'(ny[YW-1:0]) * CW'(GRID_X)
                    + CW'(nx[XW-1:0]);

    // Shared multiplier: cell coordinates, radius squared, distance squares, pressure.
    always_comb
    begin
        case (state_reg)
            S_MX:
            begin
                mul_a = {{2{px_reg[23]}}, px_reg} - {{2{cfg.origin_x[23]}}, cfg.origin_x};
                mul_b = {9'b0, cfg.cell_scale};
            end
            S_MY:
            begin
                mul_a = {{2{py_reg[23]}}, py_reg} - {{2{cfg.origin_y[23]}}, cfg.origin_y};
                mul_b = {9'b0, cfg.cell_scale};
            end
            S_MZ:
            begin
                mul_a = {{2{pz_reg[23]}}, pz_reg} - {{2{cfg.origin_z[23]}}, cfg.origin_z};
                mul_b = {9'b0, cfg.cell_scale};
            end
            S_MC:
            begin
                mul_a = {3'b0, cfg.radius};
                mul_b = {10'b0, cfg.radius};
            end
            S_DX:
            begin
                mul_a = {{2{qx[23]}}, qx} - {{2{px_reg[23]}}, px_reg};
                mul_b = {{7{mul_a[25]}}, mul_a};
            end
            S_DY:
            begin
                mul_a = {{2{qy[23]}}, qy} - {{2{py_reg[23]}}, py_reg};
                mul_b = {{7{mul_a[25]}}, mul_a};
            end
            S_DZ:
            begin
                mul_a = {{2{qz[23]}}, qz} - {{2{pz_reg[23]}}, pz_reg};
                mul_b = {{7{mul_a[25]}}, mul_a};
            end
            S_PR:
            begin
                mul_a = {2'b0, dens_diff};
                mul_b = {1'b0, gain_sel};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        query_next     = query_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        kind_next      = kind_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        r2_next        = r2_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        lin_next       = lin_reg;
        tail_next      = tail_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        d2_next        = d2_reg;
        dens_next      = dens_reg;
        press_next     = press_reg;
        oog_next       = oog_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        pos_we     = 1'b0;
        pos_waddr  = in_slot;
        pos_wdata  = {in_data.pos_x, in_data.pos_y, in_data.pos_z, in_data.kind};
        pos_re     = 1'b0;
        pos_raddr  = (state_reg == S_IDLE) ? in_slot : j_reg[IW-1:0];
        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = EMPTY;
        link_re    = 1'b0;
        link_raddr = j_reg[IW-1:0];
        cell_we    = 1'b0;
        cell_waddr = lin_reg;
        cell_wdata = '1;
        cell_re    = 1'b0;
        cell_raddr = lin_reg;
        wu_start   = 1'b0;
        wu_d2      = d2_reg[45:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_cnt_reg;
                if (clr_cnt_reg == CW'(NCELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.opcode)
                        clpp_pkg::OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLR;
                        end
                        clpp_pkg::OP_INSERT:
                        begin
                            query_next = 1'b0;
                            slot_next  = in_slot;
                            px_next    = in_data.pos_x;
                            py_next    = in_data.pos_y;
                            pz_next    = in_data.pos_z;
                            kind_next  = in_data.kind;
                            ox_next    = 2'd1;
                            oy_next    = 2'd1;
                            oz_next    = 2'd1;
                            if (idx_ok)
                            begin
                                pos_we = 1'b1;
                                if (clpp_pkg::is_real(in_data.kind))
                                begin
                                    state_next = S_MX;
                                end
                            end
                        end
                        clpp_pkg::OP_QUERY:
                        begin
                            query_next = 1'b1;
                            idx_next   = in_data.particle_index;
                            slot_next  = in_slot;
                            dens_next  = '0;
                            press_next = '0;
                            oog_next   = 1'b0;
                            ox_next    = 2'd0;
                            oy_next    = 2'd0;
                            oz_next    = 2'd0;
                            if (idx_ok)
                            begin
                                pos_re     = 1'b1;
                                state_next = S_CHK;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHK:
            begin
                px_next   = qx;
                py_next   = qy;
                pz_next   = qz;
                kind_next = qk;
                state_next = clpp_pkg::is_real(qk) ? S_MX : S_OUT;
            end
            S_MX:
            begin
                state_next = S_MY;
            end
            S_MY:
            begin
                // floor of Q16.32 product, plus one
                cx_next    = prod_reg[49:32] + 18'd1;
                state_next = S_MZ;
            end
            S_MZ:
            begin
                cy_next    = prod_reg[49:32] + 18'd1;
                state_next = S_MC;
            end
            S_MC:
            begin
                cz_next    = prod_reg[49:32] + 18'd1;
                state_next = query_reg ? S_R2 : S_LIN;
            end
            S_LIN:
            begin
                lin_next   = lin_calc;
                state_next = in_g ? S_CRD : S_IDLE;
            end
            S_CRD:
            begin
                cell_re    = 1'b1;
                state_next = S_CWT;
            end
            S_CWT:
            begin
                tail_next  = tail_rd;
                link_we    = 1'b1;
                cell_we    = 1'b1;
                cell_wdata = {(tail_rd < PMAX) ? head_rd : {1'b0, slot_reg}, {1'b0, slot_reg}};
                state_next = S_LNK;
            end
            S_LNK:
            begin
                // link written after the slot's own terminator, so a self tail cycles
                if (tail_reg < PMAX)
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg[IW-1:0];
                    link_wdata = {1'b0, slot_reg};
                end
                state_next = S_IDLE;
            end
            S_R2:
            begin
                r2_next    = prod_reg[45:0];
                state_next = S_NB;
            end
            S_NB:
            begin
                lin_next = lin_calc;
                if (in_g)
                begin
                    state_next = S_HRD;
                end
                else
                begin
                    oog_next   = 1'b1;
                    state_next = S_NXT;
                end
            end
            S_HRD:
            begin
                cell_re    = 1'b1;
                state_next = S_HWT;
            end
            S_HWT:
            begin
                j_next     = head_rd;
                n_next     = '0;
                state_next = S_WLK;
            end
            S_WLK:
            begin
                if ((j_reg < PMAX) && (n_reg < PMAX))
                begin
                    n_next     = n_reg + 1'b1;
                    pos_re     = 1'b1;
                    link_re    = 1'b1;
                    state_next = S_WWT;
                end
                else
                begin
                    state_next = S_NXT;
                end
            end
            S_WWT:
            begin
                j_next = link_rdata;
                if ((j_reg != {1'b0, slot_reg}) && clpp_pkg::is_real(qk))
                begin
                    state_next = S_DX;
                end
                else
                begin
                    state_next = S_WLK;
                end
            end
            S_DX:
            begin
                state_next = S_DY;
            end
            S_DY:
            begin
                d2_next    = 52'(prod_reg[50:0]);
                state_next = S_DZ;
            end
            S_DZ:
            begin
                d2_next    = d2_reg + 52'(prod_reg[50:0]);
                state_next = S_DS;
            end
            S_DS:
            begin
                d2_next    = d2_reg + 52'(prod_reg[50:0]);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (d2_reg < {6'b0, r2_reg})
                begin
                    wu_start   = 1'b1;
                    state_next = S_WU;
                end
                else
                begin
                    state_next = S_WLK;
                end
            end
            S_WU:
            begin
                if (wu_done)
                begin
                    dens_next  = (dens_sum[39:24] != 16'd0) ? 24'hFF_FFFF : dens_sum[23:0];
                    state_next = S_WLK;
                end
            end
            S_NXT:
            begin
                state_next = S_NB;
                if (ox_reg == 2'd2)
                begin
                    ox_next = 2'd0;
                    if (oy_reg == 2'd2)
                    begin
                        oy_next = 2'd0;
                        if (oz_reg == 2'd2)
                        begin
                            state_next = S_PR;
                        end
                        else
                        begin
                            oz_next = oz_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        oy_next = oy_reg + 2'd1;
                    end
                end
                else
                begin
                    ox_next = ox_reg + 2'd1;
                end
            end
            S_PR:
            begin
                if (dens_reg > cfg.rest_density)
                begin
                    state_next = S_PW;
                end
                else
                begin
                    press_next = '0;
                    state_next = S_OUT;
                end
            end
            S_PW:
            begin
                press_next = (prod_reg[55:48] != 8'd0) ? 32'hFFFF_FFFF : prod_reg[47:16];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.result_index = idx_reg;
                    out_data_next.density      = dens_reg;
                    out_data_next.pressure     = press_reg;
                    out_data_next.out_of_grid  = oog_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg    <= query_next;
        idx_reg      <= idx_next;
        slot_reg     <= slot_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        pz_reg       <= pz_next;
        kind_reg     <= kind_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        r2_reg       <= r2_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        oz_reg       <= oz_next;
        lin_reg      <= lin_next;
        tail_reg     <= tail_next;
        j_reg        <= j_next;
        n_reg        <= n_next;
        d2_reg       <= d2_next;
        dens_reg     <= dens_next;
        press_reg    <= press_next;
        oog_reg      <= oog_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
